// File: sv/qte_pkg.sv
// qte_pkg: widths, constants, types and the CORDIC and rounding helpers
// shared by the quaternion to Euler angle unit, its cells and its channels.
// Depends on nothing.
package qte_pkg;

   localparam int CORDIC_STEPS       = 16;
   localparam int QUAT_FRACTION_BITS = 14;
   localparam int ANGLE_TABLE_LEN    = 24;
   localparam int STEP_COUNT = (CORDIC_STEPS < ANGLE_TABLE_LEN) ? CORDIC_STEPS : ANGLE_TABLE_LEN;

   localparam int QW   = 16;  // quaternion component
   localparam int PW   = 32;  // product of two components
   localparam int SUMW = 34;  // sums of products times two
   localparam int CW   = 37;  // cordic x and y
   localparam int AW   = 26;  // angle accumulator, 1/65536 degree
   localparam int S30W = 32;  // asin argument with 30 fraction bits
   localparam int SW   = 62;  // square root radicand and root
   localparam int IW   = 5;   // step index
   localparam int SQRT_STEPS = 31;
   localparam int XW   = 16;
   localparam int YW   = 15;

   localparam int UNIT_SHIFT  = 2 * QUAT_FRACTION_BITS;
   localparam int ALIGN_SHIFT = 30 - 2 * QUAT_FRACTION_BITS;
   localparam int ROUND_SHIFT = 9;

   localparam logic signed [SUMW-1:0] S_UNIT     = SUMW'(1) <<< UNIT_SHIFT;
   localparam logic signed [AW-1:0]   DEG180     = AW'(180 * 65536);
   localparam logic signed [AW-1:0]   ROUND_BIAS = AW'(256);
   localparam logic signed [AW-1:0]   XZ_LIMIT   = AW'(23040);
   localparam logic signed [AW-1:0]   Y_LIMIT    = AW'(11520);
   localparam logic [SW-1:0]          SQRT_ONE   = SW'(1) << (2 * (SQRT_STEPS - 1));

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [AW-1:0] acc;
      logic                 zero;
   } cordic_type;

   typedef struct packed {
      cordic_type ax;
      cordic_type ay;
      cordic_type az;
      logic       clamped;
   } lanes_type;

   typedef struct packed {
      logic signed [CW-1:0]   ax_y;
      logic signed [CW-1:0]   ax_x;
      logic signed [CW-1:0]   az_y;
      logic signed [CW-1:0]   az_x;
      logic signed [S30W-1:0] s30;
      logic                   clamped;
   } side_type;

   typedef struct packed {
      logic [SW-1:0] rem;
      logic [SW-1:0] root;
   } sqrt_type;

   // atan(2^-i) in 1/65536 degree
   function automatic logic signed [AW-1:0] atan_entry(input logic [IW-1:0] i);
      logic signed [AW-1:0] r;
      case (i)
         5'd0:    r = AW'(2949120);
         5'd1:    r = AW'(1740967);
         5'd2:    r = AW'(919879);
         5'd3:    r = AW'(466945);
         5'd4:    r = AW'(234379);
         5'd5:    r = AW'(117304);
         5'd6:    r = AW'(58666);
         5'd7:    r = AW'(29335);
         5'd8:    r = AW'(14668);
         5'd9:    r = AW'(7334);
         5'd10:   r = AW'(3667);
         5'd11:   r = AW'(1833);
         5'd12:   r = AW'(917);
         5'd13:   r = AW'(458);
         5'd14:   r = AW'(229);
         5'd15:   r = AW'(115);
         5'd16:   r = AW'(57);
         5'd17:   r = AW'(29);
         5'd18:   r = AW'(14);
         5'd19:   r = AW'(7);
         5'd20:   r = AW'(4);
         5'd21:   r = AW'(2);
         5'd22:   r = AW'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

   // fold the left half plane onto the right one
   function automatic cordic_type cordic_prep(input logic signed [CW-1:0] y,
                                              input logic signed [CW-1:0] x);
      cordic_type c;
      c.zero = (x == 0) && (y == 0);
      c.x    = x;
      c.y    = y;
      c.acc  = '0;
      if (x < 0) begin
         c.acc = (y >= 0) ? DEG180 : -DEG180;
         c.x   = -x;
         c.y   = -y;
      end
      return c;
   endfunction

   function automatic cordic_type cordic_step(input cordic_type c, input logic [IW-1:0] i);
      cordic_type r;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      dx = c.y >>> i;
      dy = c.x >>> i;
      r  = c;
      if (c.y > 0) begin
         r.x   = c.x + dx;
         r.y   = c.y - dy;
         r.acc = c.acc + atan_entry(i);
      end else begin
         r.x   = c.x - dx;
         r.y   = c.y + dy;
         r.acc = c.acc - atan_entry(i);
      end
      return r;
   endfunction

   function automatic logic signed [AW-1:0] to_units(input cordic_type c,
                                                     input logic signed [AW-1:0] limit);
      logic signed [AW-1:0] r;
      r = (c.acc + ROUND_BIAS) >>> ROUND_SHIFT;
      if (r > limit)
         r = limit;
      if (r < -limit)
         r = -limit;
      if (c.zero)
         r = '0;
      return r;
   endfunction

endpackage

// File: sv/qte_req_if.sv
// qte_req_if: request channel carrying one quaternion per transaction
// depends on qte_pkg for the component width
interface qte_req_if;
   logic                        valid;
   logic                        ready;
   logic signed [qte_pkg::QW-1:0] quat_w;
   logic signed [qte_pkg::QW-1:0] quat_x;
   logic signed [qte_pkg::QW-1:0] quat_y;
   logic signed [qte_pkg::QW-1:0] quat_z;

   modport source (output valid, output quat_w, output quat_x, output quat_y,
                   output quat_z, input ready);
   modport sink (input valid, input quat_w, input quat_x, input quat_y,
                 input quat_z, output ready);
endinterface

// File: sv/qte_rsp_if.sv
// qte_rsp_if: response channel carrying three Euler angles and the asin flag
// depends on qte_pkg for the angle widths
interface qte_rsp_if;
   logic                          valid;
   logic                          ready;
   logic signed [qte_pkg::XW-1:0] angle_about_x;
   logic signed [qte_pkg::YW-1:0] angle_about_y;
   logic signed [qte_pkg::XW-1:0] angle_about_z;
   logic                          asin_clamped;

   modport source (output valid, output angle_about_x, output angle_about_y,
                   output angle_about_z, output asin_clamped, input ready);
   modport sink (input valid, input angle_about_x, input angle_about_y,
                 input angle_about_z, input asin_clamped, output ready);
endinterface

// File: sv/qte_sqrt_cell.sv
// qte_sqrt_cell: one step of the integer square root, one root bit per cell
// depends on qte_pkg; carries the cordic operands alongside
module qte_sqrt_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic [qte_pkg::IW-1:0]  step,
   input  logic                    prev_valid,
   input  qte_pkg::sqrt_type       prev_sq,
   input  qte_pkg::side_type       prev_side,
   output logic                    next_valid,
   output qte_pkg::sqrt_type       next_sq,
   output qte_pkg::side_type       next_side
);
   import qte_pkg::*;

   logic [SW-1:0] bit_w;
   logic [SW-1:0] trial;
   logic          valid_ff, valid_in;
   sqrt_type      sq_ff, sq_in;
   side_type      side_ff, side_in;

   always_comb begin
      bit_w = SW'(1) << {(IW'(SQRT_STEPS - 1) - step), 1'b0};
      trial = prev_sq.root + bit_w;
      if (prev_sq.rem >= trial) begin
         sq_in.rem  = prev_sq.rem - trial;
         sq_in.root = (prev_sq.root >> 1) + bit_w;
      end else begin
         sq_in.rem  = prev_sq.rem;
         sq_in.root = prev_sq.root >> 1;
      end
      valid_in = enable ? prev_valid : valid_ff;
      side_in  = prev_side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         sq_ff   <= sq_in;
         side_ff <= side_in;
      end
   end

   assign next_valid = valid_ff;
   assign next_sq    = sq_ff;
   assign next_side  = side_ff;
endmodule

// File: sv/qte_cordic_cell.sv
// qte_cordic_cell: one vectoring micro-rotation for the three angle lanes
// depends on qte_pkg for the lane types and the arctangent table
module qte_cordic_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic [qte_pkg::IW-1:0] step,
   input  logic                   prev_valid,
   input  qte_pkg::lanes_type     prev_lanes,
   output logic                   next_valid,
   output qte_pkg::lanes_type     next_lanes
);
   import qte_pkg::*;

   logic      valid_ff, valid_in;
   lanes_type lanes_ff, lanes_in;

   always_comb begin
      lanes_in.ax      = cordic_step(prev_lanes.ax, step);
      lanes_in.ay      = cordic_step(prev_lanes.ay, step);
      lanes_in.az      = cordic_step(prev_lanes.az, step);
      lanes_in.clamped = prev_lanes.clamped;
      valid_in         = enable ? prev_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (enable) begin
         lanes_ff <= lanes_in;
      end
   end

   assign next_valid = valid_ff;
   assign next_lanes = lanes_ff;
endmodule

// File: sv/quaternion_to_euler_angles_unit.sv
// Quaternion to Euler angle unit: takes one Q1.14 quaternion per transaction
// and returns roll, pitch and yaw in 1/128 degree with an asin saturation flag.
// The unit accepts a new transaction every cycle while the response side is not
// stalling, and passes each one through the product, sum, asin square and
// radicand registers, 31 root-extraction cells (one root bit each), one quadrant
// fold, one CORDIC cell per micro-rotation (16) and the output register. A stall on
// the response side holds the whole chain, and the request side takes a new
// transaction whenever the output register is empty or being drained.
// Depends on qte_pkg, qte_req_if, qte_rsp_if, qte_sqrt_cell, qte_cordic_cell.
module quaternion_to_euler_angles_unit (
   input logic      clock,
   input logic      reset,
   qte_req_if.sink  req_chan,
   qte_rsp_if.source rsp_chan
);
   import qte_pkg::*;

   logic adv;

   // products
   logic signed [PW-1:0] ww_ff, xx_ff, yy_ff, zz_ff, yz_ff, xw_ff, xy_ff, zw_ff, yw_ff, xz_ff;
   logic                 v1_ff;
   // sums
   logic signed [SUMW-1:0] s_full, s_sat;
   logic signed [S30W-1:0] s30_w;
   side_type             side2_ff, side2_in;
   logic                 v2_ff;
   // square of the asin argument
   logic [S30W-2:0]      mag;
   logic [SW-1:0]        sq_prod;
   logic [SW-1:0]        sq3_ff;
   side_type             side3_ff;
   logic                 v3_ff;
   // radicand
   sqrt_type             sq4_ff;
   side_type             side4_ff;
   logic                 v4_ff;

   logic                 sqrt_valid [0:SQRT_STEPS];
   sqrt_type             sqrt_chain [0:SQRT_STEPS];
   side_type             side_chain [0:SQRT_STEPS];

   logic                 cor_valid [0:STEP_COUNT];
   lanes_type            cor_chain [0:STEP_COUNT];
   lanes_type            prep_in;
   logic                 prep_valid_ff;
   lanes_type            prep_ff;

   logic                   out_valid_ff;
   logic signed [XW-1:0]   ax_ff, az_ff;
   logic signed [YW-1:0]   ay_ff;
   logic                   clamped_ff;

   assign adv            = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_comb begin
      s_full = (SUMW'(yw_ff) - SUMW'(xz_ff)) <<< 1;
      side2_in.clamped = 1'b0;
      s_sat = s_full;
      if (s_full > S_UNIT) begin
         s_sat = S_UNIT;
         side2_in.clamped = 1'b1;
      end else if (s_full < -S_UNIT) begin
         s_sat = -S_UNIT;
         side2_in.clamped = 1'b1;
      end
      s30_w = (ALIGN_SHIFT >= 0) ? S30W'(s_sat <<< ALIGN_SHIFT)
                                 : S30W'(s_sat >>> (-ALIGN_SHIFT));
      side2_in.s30  = s30_w;
      side2_in.ax_y = CW'((SUMW'(yz_ff) + SUMW'(xw_ff)) <<< 1);
      side2_in.ax_x = CW'(SUMW'(ww_ff) - SUMW'(xx_ff) - SUMW'(yy_ff) + SUMW'(zz_ff));
      side2_in.az_y = CW'((SUMW'(xy_ff) + SUMW'(zw_ff)) <<< 1);
      side2_in.az_x = CW'(SUMW'(ww_ff) + SUMW'(xx_ff) - SUMW'(yy_ff) - SUMW'(zz_ff));
   end

   always_comb begin
      mag     = (S30W-1)'((side2_ff.s30 < 0) ? -side2_ff.s30 : side2_ff.s30);
      sq_prod = mag * mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_chan.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      if (adv) begin
         ww_ff <= PW'(req_chan.quat_w) * PW'(req_chan.quat_w);
         xx_ff <= PW'(req_chan.quat_x) * PW'(req_chan.quat_x);
         yy_ff <= PW'(req_chan.quat_y) * PW'(req_chan.quat_y);
         zz_ff <= PW'(req_chan.quat_z) * PW'(req_chan.quat_z);
         yz_ff <= PW'(req_chan.quat_y) * PW'(req_chan.quat_z);
         xw_ff <= PW'(req_chan.quat_x) * PW'(req_chan.quat_w);
         xy_ff <= PW'(req_chan.quat_x) * PW'(req_chan.quat_y);
         zw_ff <= PW'(req_chan.quat_z) * PW'(req_chan.quat_w);
         yw_ff <= PW'(req_chan.quat_y) * PW'(req_chan.quat_w);
         xz_ff <= PW'(req_chan.quat_x) * PW'(req_chan.quat_z);
         side2_ff    <= side2_in;
         sq3_ff      <= sq_prod;
         side3_ff    <= side2_ff;
         sq4_ff.rem  <= SQRT_ONE - sq3_ff;
         sq4_ff.root <= '0;
         side4_ff    <= side3_ff;
      end
   end

   assign sqrt_valid[0] = v4_ff;
   assign sqrt_chain[0] = sq4_ff;
   assign side_chain[0] = side4_ff;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      qte_sqrt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .enable     (adv),
         .step       (IW'(k)),
         .prev_valid (sqrt_valid[k]),
         .prev_sq    (sqrt_chain[k]),
         .prev_side  (side_chain[k]),
         .next_valid (sqrt_valid[k+1]),
         .next_sq    (sqrt_chain[k+1]),
         .next_side  (side_chain[k+1])
      );
   end

   // quadrant fold for all three lanes; the root is the asin cosine
   always_comb begin
      prep_in.ax = cordic_prep(side_chain[SQRT_STEPS].ax_y, side_chain[SQRT_STEPS].ax_x);
      prep_in.az = cordic_prep(side_chain[SQRT_STEPS].az_y, side_chain[SQRT_STEPS].az_x);
      prep_in.ay = cordic_prep(CW'(side_chain[SQRT_STEPS].s30),
                               CW'(sqrt_chain[SQRT_STEPS].root));
      prep_in.clamped = side_chain[SQRT_STEPS].clamped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (adv) begin
         prep_valid_ff <= sqrt_valid[SQRT_STEPS];
      end
      if (adv) begin
         prep_ff <= prep_in;
      end
   end

   assign cor_valid[0] = prep_valid_ff;
   assign cor_chain[0] = prep_ff;

   for (genvar k = 0; k < STEP_COUNT; k++) begin : g_cordic
      qte_cordic_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .enable     (adv),
         .step       (IW'(k)),
         .prev_valid (cor_valid[k]),
         .prev_lanes (cor_chain[k]),
         .next_valid (cor_valid[k+1]),
         .next_lanes (cor_chain[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= cor_valid[STEP_COUNT];
      end
      if (adv) begin
         ax_ff      <= XW'(to_units(cor_chain[STEP_COUNT].ax, XZ_LIMIT));
         ay_ff      <= YW'(to_units(cor_chain[STEP_COUNT].ay, Y_LIMIT));
         az_ff      <= XW'(to_units(cor_chain[STEP_COUNT].az, XZ_LIMIT));
         clamped_ff <= cor_chain[STEP_COUNT].clamped;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.angle_about_x = ax_ff;
   assign rsp_chan.angle_about_y = ay_ff;
   assign rsp_chan.angle_about_z = az_ff;
   assign rsp_chan.asin_clamped  = clamped_ff;

`ifndef ASSERT_OFF
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request taken while the output register is stalled");

   a_accept_enters_chain: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> v1_ff)
      else $error("accepted transaction missing from the product stage");

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (ax_ff <= XW'(23040)) && (ax_ff >= -XW'(23040)))
      else $error("roll out of range");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (ay_ff <= YW'(11520)) && (ay_ff >= -YW'(11520)))
      else $error("pitch out of range");
`endif
endmodule
